// ----- hdl/cts_pkg.sv -----
// ----------------------------------------------------------------------------
// Calculator token scanner package
// Token kinds and the structs passed between the scanner front, the
// descriptor queue and the emitter back.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int LEN_W = 6;
  localparam int KIND_W = 4;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_NUMBER   = 4'd0;
  localparam kind_t KIND_OPERATOR = 4'd1;
  localparam kind_t KIND_SIN      = 4'd2;
  localparam kind_t KIND_COS      = 4'd3;
  localparam kind_t KIND_EXP      = 4'd4;
  localparam kind_t KIND_POW      = 4'd5;
  localparam kind_t KIND_VAR_SET  = 4'd6;
  localparam kind_t KIND_VAR_GET  = 4'd7;
  localparam kind_t KIND_UNKNOWN  = 4'd8;

  typedef struct packed {
    logic             has_run;
    logic             bank;
    logic [LEN_W-1:0] len;
    kind_t            kind;
    logic             trunc;
    logic             has_op;
    logic [7:0]       op_ch;
  } desc_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [LEN_W-1:0] idx;
    logic [7:0]       data;
  } wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } release_t;

endpackage

// ----- hdl/calculator_token_scanner.sv -----
// Throughput: one character per cycle in while the input is not stalled; out,
// each run is sent as a descriptor load, then one bank read per cycle while
// the result register is free or popped, then any trailing operator.
// Input stalls while the bank a new token would start in still holds an
// unsent run, or while a descriptor is due and the queue is full.
// Reset: synchronous; clears the scan mode, length, flags, queue, result valid.
// ----------------------------------------------------------------------------
// Calculator token scanner
// Splits a character stream into number, operator, function and variable
// tokens and sends each token's text as a tagged run.
// ----------------------------------------------------------------------------
module calculator_token_scanner #(
  parameter int MAX_TOKEN = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] ch,
  input  logic       push,
  output logic       full,
  output logic [7:0] text_char,
  output logic [3:0] kind,
  output logic       last,
  output logic       truncated,
  output logic       empty,
  input  logic       pop
);

  cts_pkg::desc_t    f_desc;
  logic              f_push;
  logic              q_full;
  cts_pkg::desc_t    q_data;
  logic              q_empty;
  logic              q_pop;
  cts_pkg::wr_t      wr;
  cts_pkg::release_t rel;

  cts_front #(.MAX_TOKEN(MAX_TOKEN)) u_front (
    .clk       (clk),
    .rst       (rst),
    .ch        (ch),
    .push      (push),
    .full      (full),
    .desc      (f_desc),
    .desc_push (f_push),
    .q_full    (q_full),
    .wr        (wr),
    .rel       (rel)
  );

  cts_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (f_desc),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_data),
    .empty (q_empty)
  );

  cts_back #(.MAX_TOKEN(MAX_TOKEN)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .wr        (wr),
    .rel       (rel),
    .pop       (pop),
    .empty     (empty),
    .text_char (text_char),
    .kind      (kind),
    .last      (last),
    .truncated (truncated)
  );

endmodule

// ----- hdl/cts_front.sv -----
// ----------------------------------------------------------------------------
// Token scanner front
// Takes characters, tracks the scan mode, writes token text into one of two
// buffer banks and posts a descriptor for each closed run and operator.
// ----------------------------------------------------------------------------
module cts_front #(
  parameter int MAX_TOKEN = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        ch,
  input  logic              push,
  output logic              full,
  output cts_pkg::desc_t    desc,
  output logic              desc_push,
  input  logic              q_full,
  output cts_pkg::wr_t      wr,
  input  cts_pkg::release_t rel
);

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_SIGN = 3'd1;
  localparam logic [2:0] MODE_INT  = 3'd2;
  localparam logic [2:0] MODE_FRAC = 3'd3;
  localparam logic [2:0] MODE_WORD = 3'd4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_CASE  = 8'h20;

  localparam logic [23:0] KW_SIN = "SIN";
  localparam logic [23:0] KW_COS = "COS";
  localparam logic [23:0] KW_EXP = "EXP";
  localparam logic [23:0] KW_POW = "POW";

  localparam logic [cts_pkg::LEN_W-1:0] LEN_MAX = cts_pkg::LEN_W'(MAX_TOKEN);

  function automatic logic is_upper(input logic [7:0] c);
    return (c inside {["A":"Z"]});
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c inside {["a":"z"]});
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return is_lower(c) ? c - CH_CASE : c;
  endfunction

  logic                      in_valid;
  logic [7:0]                in_ch;
  logic [2:0]                mode;
  logic [cts_pkg::LEN_W-1:0] len;
  logic                      ovf;
  logic                      wbank;
  logic [1:0]                busy;
  logic [1:0]                busy_next;
  logic [7:0]                w0;
  logic [7:0]                w1;
  logic [7:0]                w2;

  logic                      dig;
  logic                      dot;
  logic                      alpha;
  logic                      skip;
  logic                      sign;
  logic                      cont;
  logic [2:0]                mode_cont;
  logic                      in_token;
  logic                      close;
  logic                      starts;
  logic [2:0]                start_mode;
  logic                      start;
  logic                      op;
  logic                      tgt_bank;
  logic                      need_push;
  logic                      go;
  logic                      room;
  cts_pkg::kind_t            word_kind;
  cts_pkg::kind_t            close_kind;
  logic [23:0]               word_up;

  assign dig   = (in_ch inside {["0":"9"]});
  assign dot   = (in_ch == CH_DOT);
  assign alpha = is_upper(in_ch) || is_lower(in_ch);
  assign skip  = (in_ch == CH_SPACE) || (in_ch == CH_TAB);
  assign sign  = (in_ch == CH_PLUS) || (in_ch == CH_MINUS);
  assign room  = (len < LEN_MAX);

  always_comb begin
    cont = 1'b0;
    mode_cont = MODE_IDLE;
    case (mode)
      MODE_SIGN: begin
        cont = dig || dot;
        mode_cont = dig ? MODE_INT : MODE_FRAC;
      end
      MODE_INT: begin
        cont = dig || dot;
        mode_cont = dot ? MODE_FRAC : MODE_INT;
      end
      MODE_FRAC: begin
        cont = dig;
        mode_cont = MODE_FRAC;
      end
      MODE_WORD: begin
        cont = alpha;
        mode_cont = MODE_WORD;
      end
      default: begin
        cont = 1'b0;
        mode_cont = MODE_IDLE;
      end
    endcase
  end

  always_comb begin
    starts = 1'b1;
    start_mode = MODE_IDLE;
    if (dig) begin
      start_mode = MODE_INT;
    end else if (dot) begin
      start_mode = MODE_FRAC;
    end else if (sign) begin
      start_mode = MODE_SIGN;
    end else if (alpha) begin
      start_mode = MODE_WORD;
    end else begin
      starts = 1'b0;
    end
  end

  assign word_up = {to_upper(w0), to_upper(w1), to_upper(w2)};

  always_comb begin
    word_kind = cts_pkg::KIND_UNKNOWN;
    if (ovf) begin
      word_kind = cts_pkg::KIND_UNKNOWN;
    end else if (len == cts_pkg::LEN_W'(1)) begin
      word_kind = is_upper(w0) ? cts_pkg::KIND_VAR_SET : cts_pkg::KIND_VAR_GET;
    end else if (len == cts_pkg::LEN_W'(3)) begin
      if (word_up == KW_SIN) word_kind = cts_pkg::KIND_SIN;
      else if (word_up == KW_COS) word_kind = cts_pkg::KIND_COS;
      else if (word_up == KW_EXP) word_kind = cts_pkg::KIND_EXP;
      else if (word_up == KW_POW) word_kind = cts_pkg::KIND_POW;
    end
  end

  always_comb begin
    case (mode)
      MODE_SIGN:           close_kind = cts_pkg::KIND_OPERATOR;
      MODE_INT, MODE_FRAC: close_kind = cts_pkg::KIND_NUMBER;
      default:             close_kind = word_kind;
    endcase
  end

  assign in_token  = (mode inside {MODE_SIGN, MODE_INT, MODE_FRAC, MODE_WORD});
  assign close     = in_token && !cont;
  assign start     = !cont && starts;
  assign op        = !cont && !skip && !starts;
  assign tgt_bank  = close ? ~wbank : wbank;
  assign need_push = close || op;
  assign go        = in_valid && !(need_push && q_full) && !(start && busy[tgt_bank]);
  assign full      = in_valid && !go;

  always_comb begin
    wr.en   = go && (start || (cont && room));
    wr.bank = start ? tgt_bank : wbank;
    wr.idx  = start ? '0 : len;
    wr.data = in_ch;
  end

  always_comb begin
    desc.has_run = close;
    desc.bank    = wbank;
    desc.len     = len;
    desc.kind    = close_kind;
    desc.trunc   = ovf;
    desc.has_op  = op;
    desc.op_ch   = in_ch;
    desc_push    = go && need_push;
  end

  always_comb begin
    busy_next = busy;
    if (rel.en) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (go && close) begin
      busy_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      mode <= MODE_IDLE;
      len <= '0;
      ovf <= 1'b0;
      wbank <= 1'b0;
      busy <= '0;
    end else begin
      busy <= busy_next;
      if (push && !full) begin
        in_valid <= 1'b1;
      end else if (go) begin
        in_valid <= 1'b0;
      end
      if (go) begin
        if (cont) begin
          if (room) begin
            len <= len + cts_pkg::LEN_W'(1);
          end else begin
            ovf <= 1'b1;
          end
          mode <= mode_cont;
        end else begin
          if (close) begin
            wbank <= ~wbank;
          end
          ovf <= 1'b0;
          if (start) begin
            len <= cts_pkg::LEN_W'(1);
            mode <= start_mode;
          end else begin
            len <= '0;
            mode <= MODE_IDLE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      in_ch <= ch;
    end
    if (wr.en) begin
      if (wr.idx == cts_pkg::LEN_W'(0)) w0 <= in_ch;
      if (wr.idx == cts_pkg::LEN_W'(1)) w1 <= in_ch;
      if (wr.idx == cts_pkg::LEN_W'(2)) w2 <= in_ch;
    end
  end

`ifndef SYNTHESIS
  a_release_busy: assert property (@(posedge clk) disable iff (rst)
    rel.en |-> busy[rel.bank]) else $error("release of an idle buffer bank");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    desc_push |-> !q_full) else $error("descriptor pushed into a full queue");
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> !busy[wr.bank]) else $error("write into a bank still being sent");
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    go && close |=> len <= cts_pkg::LEN_W'(1)) else $error("length not restarted");
`endif

endmodule

// ----- hdl/cts_queue.sv -----
// ----------------------------------------------------------------------------
// Descriptor queue
// Short queue of token descriptors between the scanner front and the
// emitter back.
// ----------------------------------------------------------------------------
module cts_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cts_pkg::desc_t din,
  output logic           full,
  input  logic           pop,
  output cts_pkg::desc_t dout,
  output logic           empty
);

  cts_pkg::desc_t               entries [cts_pkg::Q_DEPTH];
  logic [cts_pkg::Q_PTR_W-1:0]  wr_ptr;
  logic [cts_pkg::Q_PTR_W-1:0]  rd_ptr;
  logic [cts_pkg::Q_CNT_W-1:0]  count;
  logic                         do_push;
  logic                         do_pop;

  assign full    = (count == cts_pkg::Q_CNT_W'(cts_pkg::Q_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + cts_pkg::Q_PTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + cts_pkg::Q_PTR_W'(1);
      if (do_push && !do_pop) begin
        count <= count + cts_pkg::Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - cts_pkg::Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

// ----- hdl/cts_back.sv -----
// ----------------------------------------------------------------------------
// Token emitter back
// Holds the two token text banks, takes descriptors from the queue and
// sends each run, then any trailing operator, through the result register.
// ----------------------------------------------------------------------------
module cts_back #(
  parameter int MAX_TOKEN = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cts_pkg::desc_t         q_data,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  cts_pkg::wr_t           wr,
  output cts_pkg::release_t      rel,
  input  logic                   pop,
  output logic                   empty,
  output logic [7:0]             text_char,
  output logic [cts_pkg::KIND_W-1:0] kind,
  output logic                   last,
  output logic                   truncated
);

  localparam int IW = $clog2(MAX_TOKEN);

  logic [7:0]     mem [2][MAX_TOKEN];
  cts_pkg::desc_t cur;
  logic           active;
  logic           op_phase;
  logic [IW-1:0]  idx;
  logic           out_valid;
  logic           can_load;
  logic           step;
  logic           run_last;

  assign can_load = !out_valid || pop;
  assign step     = active && can_load;
  assign run_last = (cts_pkg::LEN_W'(idx) + cts_pkg::LEN_W'(1) == cur.len);
  assign q_pop    = !active && !q_empty;
  assign empty    = !out_valid;

  always_comb begin
    rel.en   = step && !op_phase && run_last;
    rel.bank = cur.bank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      op_phase <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        active <= 1'b1;
        op_phase <= !q_data.has_run;
      end else if (step) begin
        if (op_phase) begin
          active <= 1'b0;
        end else if (run_last) begin
          if (cur.has_op) begin
            op_phase <= 1'b1;
          end else begin
            active <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.bank][wr.idx[IW-1:0]] <= wr.data;
    end
    if (q_pop) begin
      cur <= q_data;
      idx <= '0;
    end else if (step && !op_phase) begin
      idx <= idx + IW'(1);
    end
    if (step) begin
      if (op_phase) begin
        text_char <= cur.op_ch;
        kind <= cts_pkg::KIND_OPERATOR;
        last <= 1'b1;
        truncated <= 1'b0;
      end else begin
        text_char <= mem[cur.bank][idx];
        kind <= cur.kind;
        last <= run_last;
        truncated <= cur.trunc;
      end
    end
  end

endmodule

// ----- bench/tb_calculator_token_scanner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calculator token scanner testbench
// Feeds character streams (a directed opening, then random well-formed
// numbers, words, variables and operators mixed with raw bytes) through the
// scanner with bursty input and a stalling output. A local tokenizer predicts
// every token character; results are checked field by field in order.
// ----------------------------------------------------------------------------
module tb_calculator_token_scanner;

  localparam int TOKEN_DEPTH = 32;
  localparam int STREAM_LEN = 410;
  localparam int HOLD_AFTER = 120;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam longint LIMIT_NS = 64'd6_000_000;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_SIGN,
    SCAN_INT,
    SCAN_FRAC,
    SCAN_WORD
  } scan_mode_t;

  typedef struct packed {
    logic [7:0]     text;
    cts_pkg::kind_t kind;
    logic           last;
    logic           trunc;
  } token_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] ch = 8'h00;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] text_char;
  logic [3:0] kind;
  logic       last;
  logic       truncated;
  logic       empty;
  logic       pop = 1'b0;

  logic [7:0]  pending_chars[$];
  token_char_t token_chars_due[$];

  scan_mode_t tok_mode = SCAN_IDLE;
  logic [7:0] tok_text[TOKEN_DEPTH];
  int         tok_len = 0;
  logic       tok_over = 1'b0;

  int          chars_taken = 0;
  int          errors = 0;
  logic        rx_hold = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  logic        rx_open = 1'b1;
  int          rx_left = 0;
  token_char_t want;

  calculator_token_scanner #(.MAX_TOKEN(TOKEN_DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .ch(ch),
    .push(push),
    .full(full),
    .text_char(text_char),
    .kind(kind),
    .last(last),
    .truncated(truncated),
    .empty(empty),
    .pop(pop)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic void append_char(input logic [7:0] c);
    if (tok_len < TOKEN_DEPTH) begin
      tok_text[tok_len] = c;
      tok_len++;
    end else begin
      tok_over = 1'b1;
    end
  endfunction

  function automatic void start_token(input logic [7:0] c, input scan_mode_t m);
    tok_len = 0;
    tok_over = 1'b0;
    append_char(c);
    tok_mode = m;
  endfunction

  function automatic cts_pkg::kind_t word_kind();
    logic [23:0] w;
    if (tok_over)
      return cts_pkg::KIND_UNKNOWN;
    if (tok_len == 1)
      return (tok_text[0] >= "A" && tok_text[0] <= "Z") ?
             cts_pkg::KIND_VAR_SET : cts_pkg::KIND_VAR_GET;
    if (tok_len == 3) begin
      w = {upcase(tok_text[0]), upcase(tok_text[1]), upcase(tok_text[2])};
      case (w)
        "SIN": return cts_pkg::KIND_SIN;
        "COS": return cts_pkg::KIND_COS;
        "EXP": return cts_pkg::KIND_EXP;
        "POW": return cts_pkg::KIND_POW;
        default: return cts_pkg::KIND_UNKNOWN;
      endcase
    end
    return cts_pkg::KIND_UNKNOWN;
  endfunction

  function automatic void flush_run(input cts_pkg::kind_t k);
    for (int i = 0; i < tok_len; i++)
      token_chars_due.push_back({tok_text[i], k, (i == tok_len - 1), tok_over});
    tok_len = 0;
    tok_over = 1'b0;
    tok_mode = SCAN_IDLE;
  endfunction

  // The character that closes a token is scanned again from idle.
  function automatic void scan_char(input logic [7:0] c);
    logic done;
    done = 1'b0;
    for (int pass = 0; pass < 2 && !done; pass++) begin
      case (tok_mode)
        SCAN_SIGN: begin
          if (is_digit(c)) begin
            append_char(c);
            tok_mode = SCAN_INT;
            done = 1'b1;
          end else if (c == ".") begin
            append_char(c);
            tok_mode = SCAN_FRAC;
            done = 1'b1;
          end else begin
            flush_run(cts_pkg::KIND_OPERATOR);
          end
        end
        SCAN_INT: begin
          if (is_digit(c)) begin
            append_char(c);
            done = 1'b1;
          end else if (c == ".") begin
            append_char(c);
            tok_mode = SCAN_FRAC;
            done = 1'b1;
          end else begin
            flush_run(cts_pkg::KIND_NUMBER);
          end
        end
        SCAN_FRAC: begin
          if (is_digit(c)) begin
            append_char(c);
            done = 1'b1;
          end else begin
            flush_run(cts_pkg::KIND_NUMBER);
          end
        end
        SCAN_WORD: begin
          if (is_alpha(c)) begin
            append_char(c);
            done = 1'b1;
          end else begin
            flush_run(word_kind());
          end
        end
        default: begin
          tok_mode = SCAN_IDLE;
          done = 1'b1;
          if (c == " " || c == "\t")
            ;
          else if (is_digit(c))
            start_token(c, SCAN_INT);
          else if (c == ".")
            start_token(c, SCAN_FRAC);
          else if (c == "+" || c == "-")
            start_token(c, SCAN_SIGN);
          else if (is_alpha(c))
            start_token(c, SCAN_WORD);
          else
            token_chars_due.push_back({c, cts_pkg::KIND_OPERATOR, 1'b1, 1'b0});
        end
      endcase
    end
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++)
      pending_chars.push_back(s[i]);
  endtask

  // Driver: bursts of items with random gaps; no gaps during the hold-off.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (push && !full) begin
        scan_char(ch);
        chars_taken <= chars_taken + 1;
      end
      if (push && full)
        ;
      else if (gap_left > 0 && !rx_hold) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_chars.size() != 0) begin
        push <= 1'b1;
        ch <= pending_chars.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(20, 60);
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = $urandom_range(1, 6);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: check each item against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      rx_open = 1'b1;
      rx_left = 0;
    end else begin
      if (pop && !empty) begin
        if (token_chars_due.size() == 0) begin
          $error("unexpected item: text_char %0h kind %0d last %0b truncated %0b",
                 text_char, kind, last, truncated);
          errors++;
        end else begin
          want = token_chars_due.pop_front();
          if (text_char !== want.text) begin
            $error("text_char: expected %0h, got %0h", want.text, text_char);
            errors++;
          end
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            errors++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            errors++;
          end
          if (truncated !== want.trunc) begin
            $error("truncated: expected %0b, got %0b", want.trunc, truncated);
            errors++;
          end
        end
      end
      if (rx_left == 0) begin
        rx_open = !rx_open;
        if (rx_open)
          rx_left = $urandom_range(1, 30);
        else if ($urandom_range(0, 5) == 0)
          rx_left = $urandom_range(6, 15);
        else
          rx_left = $urandom_range(1, 3);
      end else begin
        rx_left--;
      end
      pop <= rx_open && !rx_hold;
    end
  end

  // Hold off the output long enough for both text banks to fill.
  initial begin
    do @(posedge clk); while (chars_taken < HOLD_AFTER);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    string      word_list[4];
    string      op_set;
    int         pick;
    int         n;
    logic [7:0] c;
    word_list = '{"sin", "cos", "exp", "pow"};
    op_set = "*/()^=%,;<>!&\n";
    add_text("sin COS(Exp pOw*A-b\tqz+.5.7");
    pending_chars.push_back(8'h00);
    pending_chars.push_back(8'hFF);
    while (pending_chars.size() < STREAM_LEN) begin
      pick = $urandom_range(0, 49);
      if (pick < 16) begin
        if ($urandom_range(0, 2) == 0)
          pending_chars.push_back($urandom_range(0, 1) ? "+" : "-");
        n = (pick == 0) ? $urandom_range(30, 36) : $urandom_range(0, 4);
        repeat (n) pending_chars.push_back(8'("0" + $urandom_range(0, 9)));
        if (n == 0 || $urandom_range(0, 1) == 1) begin
          pending_chars.push_back(".");
          repeat ($urandom_range(0, 3)) pending_chars.push_back(8'("0" + $urandom_range(0, 9)));
        end
      end else if (pick < 28) begin
        case ($urandom_range(0, 2))
          0: n = 1;
          1: n = $urandom_range(2, 6);
          default: n = 0;
        endcase
        if (pick == 27)
          n = $urandom_range(30, 36);
        if (n == 0) begin
          for (int j = 0; j < 3; j++) begin
            c = word_list[$urandom_range(0, 3)][j];
            pending_chars.push_back($urandom_range(0, 1) ? c - 8'd32 : c);
          end
        end else begin
          repeat (n)
            pending_chars.push_back(8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25)));
        end
      end else if (pick < 38) begin
        if ($urandom_range(0, 2) == 0)
          pending_chars.push_back($urandom_range(0, 1) ? "+" : "-");
        else
          pending_chars.push_back(op_set[$urandom_range(0, op_set.len() - 1)]);
      end else if (pick < 44) begin
        repeat ($urandom_range(1, 3)) pending_chars.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 2)) pending_chars.push_back($urandom_range(0, 1) ? " " : "\t");
      end
      if ($urandom_range(0, 2) == 0)
        pending_chars.push_back(" ");
    end

    do @(posedge clk); while (rst || pending_chars.size() != 0 || push);
    while (token_chars_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
